>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold whenever trig holds
`define ASSERT_IMPL(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);
// cond must hold in the cycle after trig
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, trig, cond, msg)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg)
`endif
`endif

>>> rtl/core/fralloc_pkg.sv
// ---------------------------------------------------------------------------
// fralloc_pkg
// Shared types, codes and defaults of the frame allocator.
// ---------------------------------------------------------------------------
package fralloc_pkg;

    localparam int NUM_FRAMES_DEF  = 4096;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam logic [12:0] FRAME_LIMIT_RST = 13'd4096;

    // request codes
    localparam logic [2:0] REQ_ALLOC_ONE = 3'd0;
    localparam logic [2:0] REQ_ALLOC_RUN = 3'd1;
    localparam logic [2:0] REQ_FREE      = 3'd2;
    localparam logic [2:0] REQ_ADD_REF   = 3'd3;
    localparam logic [2:0] REQ_READ      = 3'd4;
    localparam logic [2:0] REQ_MARK      = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OOM      = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LATCH,
        DP_RESULT,
        DP_SCAN_INIT,
        DP_SCAN_WORD,
        DP_SCAN_BIT,
        DP_WALK_ALLOC,
        DP_WALK_MARK,
        DP_WALK_LOAD,
        DP_WALK_BIT,
        DP_FRAME_RD,
        DP_FRAME_OP,
        DP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] code;   // status for DP_RESULT
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic dec_alloc;
        logic dec_frame;
        logic dec_mark;
        logic len_bad;
        logic len_oom;
        logic frame_bad;
        logic mark_nop;
        logic past_lim;
        logic word_found;
        logic word_skip;
        logic bit_found;
        logic word_end;
        logic walk_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/frame_allocator_refcount_unit.sv
// ---------------------------------------------------------------------------
// frame_allocator_refcount_unit
// Bitmap page-frame allocator with per-frame reference counts.
// ---------------------------------------------------------------------------
// One item in, one result item out. After reset a clearing pass zeroes
// the count memory and sets every used bit; no item is taken meanwhile
// (frame_limit writes are). Items are handled one at a time. Allocation
// scans the used-bit memory a 64-bit word at a time, skipping words that
// are fully used or fully free, and walks a partly used word one frame per
// cycle; the run found is then written one frame per cycle, with a read of
// each word touched before its frames. Mark region is walked the same way.
// The result sits in an output register, so the next item is taken while
// it waits.
module frame_allocator_refcount_unit #(
    parameter int NUM_FRAMES  = fralloc_pkg::NUM_FRAMES_DEF,
    parameter int COUNT_WIDTH = fralloc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,   // frame_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // req_type[2:0] frame[14:3] run_length[27:15] mark_used[28]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status[2:0] result_frame[14:3] ref_count[30:15] free_count[43:31]
);
    import fralloc_pkg::*;
    `include "assert_macros.svh"

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [43:0] out_data;

    fralloc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fralloc_dp #(
        .NUM_FRAMES  (NUM_FRAMES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_data  (cfg_wr_data),
        .cfg_we    (cfg_wr_en),
        .in_data   (s_axis_tdata[28:0]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {4'd0, out_data};

    // one item in flight: no second accept right after one
    `ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accept while busy")
    // free count stays within the tracked frames
    `ASSERT_IMPL(a_free_range, clk, rst_n, m_axis_tvalid, 32'(m_axis_tdata[43:31]) <= NUM_FRAMES, "free count out of range")
    // status code is a defined one
    `ASSERT_IMPL(a_status_code, clk, rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= ST_OVERFLOW, "bad status code")

endmodule

>>> rtl/core/fralloc_dp.sv
// ---------------------------------------------------------------------------
// fralloc_dp
// Datapath: used-bit and count memories, scan and walk registers, result.
// ---------------------------------------------------------------------------
module fralloc_dp #(
    parameter int NUM_FRAMES  = fralloc_pkg::NUM_FRAMES_DEF,
    parameter int COUNT_WIDTH = fralloc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fralloc_pkg::dp_cmd_t  cmd,
    output fralloc_pkg::dp_stat_t stat,
    input  logic [12:0]         cfg_data,
    input  logic                cfg_we,
    input  logic [28:0]         in_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [43:0]         out_data
);
    import fralloc_pkg::*;

    localparam int FW    = $clog2(NUM_FRAMES);
    localparam int CW    = FW + 1;
    localparam int XW    = ((CW > 13) ? CW : 13) + 1;
    localparam int WORDS = (NUM_FRAMES + 63) / 64;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [63:0]          used_mem [WORDS];
    logic [COUNT_WIDTH-1:0] cnt_mem [NUM_FRAMES];
    logic [63:0]          used_q;
    logic [COUNT_WIDTH-1:0] cnt_q;

    logic [12:0]   flim_reg, flim_next;
    logic [XW-1:0] lim_reg, len_reg, cur_reg, end_reg, run_reg, start_reg;
    logic [XW-1:0] lim_next, len_next, cur_next, end_next, run_next, start_next;
    logic [2:0]    req_reg, req_next;
    logic [11:0]   frame_reg, frame_next;
    logic          mu_reg, mu_next;
    logic [63:0]   word_reg, word_next;
    logic [CW-1:0] ft_reg, ft_next;
    logic [FW-1:0] clr_reg, clr_next;
    logic [2:0]    rst_reg, rst_next;
    logic [11:0]   rfr_reg, rfr_next;
    logic [15:0]   rcn_reg, rcn_next;
    logic          ov_reg, ov_next;
    logic [43:0]   od_reg, od_next;

    logic          used_we, cnt_we;
    logic [AW-1:0] used_waddr, used_raddr;
    logic [63:0]   used_wdata;
    logic [FW-1:0] cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;

    logic [XW-1:0] fx, lim_in, mark_sum, walk_end;
    logic          full_in, all1, all0, cur_bit, fbit, nb;
    logic [5:0]    idx;
    logic [63:0]   word_upd;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // memories
    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        used_q <= used_mem[used_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[FW'(frame_reg)];
    end

    assign fx       = XW'(frame_reg);
    assign idx      = cur_reg[5:0];
    assign cur_bit  = word_reg[idx];
    assign fbit     = used_q[frame_reg[5:0]];
    assign full_in  = (cur_reg + XW'(64)) <= lim_reg;
    assign all1     = &used_q;
    assign all0     = ~|used_q;
    assign mark_sum = fx + len_reg;
    assign walk_end = (mark_sum > lim_reg) ? lim_reg : mark_sum;
    assign lim_in   = (XW'(flim_reg) > XW'(NUM_FRAMES)) ? XW'(NUM_FRAMES) : XW'(flim_reg);
    assign nb       = (req_reg == REQ_MARK) ? mu_reg : 1'b1;

    always_comb
    begin
        word_upd      = word_reg;
        word_upd[idx] = nb;
    end

    assign used_raddr = (cmd.op == DP_FRAME_RD) ? AW'(frame_reg >> 6) : AW'(cur_reg >> 6);

    // status
    always_comb
    begin
        stat.clr_done   = clr_reg == FW'(NUM_FRAMES - 1);
        stat.dec_alloc  = (req_reg == REQ_ALLOC_ONE) || (req_reg == REQ_ALLOC_RUN);
        stat.dec_frame  = (req_reg == REQ_FREE) || (req_reg == REQ_ADD_REF) ||
                          (req_reg == REQ_READ);
        stat.dec_mark   = req_reg == REQ_MARK;
        stat.len_bad    = len_reg == '0;
        stat.len_oom    = len_reg > lim_reg;
        stat.frame_bad  = (fx == '0) || (fx >= lim_reg);
        stat.mark_nop   = (fx >= lim_reg) || (len_reg == '0);
        stat.past_lim   = cur_reg >= lim_reg;
        stat.word_found = full_in && all0 && ((run_reg + XW'(64)) >= len_reg);
        stat.word_skip  = full_in && (all1 || all0);
        stat.bit_found  = !cur_bit && ((run_reg + XW'(1)) == len_reg);
        stat.word_end   = idx == 6'd63;
        stat.walk_last  = (cur_reg + XW'(1)) == end_reg;
        stat.out_free   = !ov_reg || out_ready;
    end

    always_comb
    begin
        flim_next  = flim_reg;
        lim_next   = lim_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        end_next   = end_reg;
        run_next   = run_reg;
        start_next = start_reg;
        req_next   = req_reg;
        frame_next = frame_reg;
        mu_next    = mu_reg;
        word_next  = word_reg;
        ft_next    = ft_reg;
        clr_next   = clr_reg;
        rst_next   = rst_reg;
        rfr_next   = rfr_reg;
        rcn_next   = rcn_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        used_we    = 1'b0;
        used_waddr = AW'(cur_reg >> 6);
        used_wdata = word_upd;
        cnt_we     = 1'b0;
        cnt_waddr  = FW'(cur_reg);
        cnt_wdata  = CNT_ONE;
        if (cfg_we)
        begin
            flim_next = cfg_data;
        end
        unique case (cmd.op)
            DP_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                if (clr_reg < FW'(WORDS))
                begin
                    used_we    = 1'b1;
                    used_waddr = AW'(clr_reg);
                    used_wdata = '1;
                end
                clr_next = clr_reg + FW'(1);
            end
            DP_LATCH:
            begin
                req_next   = in_data[2:0];
                frame_next = in_data[14:3];
                len_next   = (in_data[2:0] == REQ_ALLOC_ONE) ? XW'(1) : XW'(in_data[27:15]);
                mu_next    = in_data[28];
                lim_next   = lim_in;
            end
            DP_RESULT:
            begin
                rst_next = cmd.code;
                rfr_next = '0;
                rcn_next = '0;
            end
            DP_SCAN_INIT:
            begin
                cur_next = '0;
                run_next = '0;
            end
            DP_SCAN_WORD:
            begin
                if (stat.word_found)
                begin
                    start_next = cur_reg - run_reg;
                end
                else if (stat.word_skip)
                begin
                    run_next = all1 ? '0 : run_reg + XW'(64);
                    cur_next = cur_reg + XW'(64);
                end
                else
                begin
                    word_next = used_q;
                end
            end
            DP_SCAN_BIT:
            begin
                run_next = cur_bit ? '0 : run_reg + XW'(1);
                if (stat.bit_found)
                begin
                    start_next = cur_reg + XW'(1) - len_reg;
                end
                cur_next = cur_reg + XW'(1);
            end
            DP_WALK_ALLOC:
            begin
                cur_next = start_reg;
                end_next = start_reg + len_reg;
                rst_next = ST_OK;
                rfr_next = 12'(start_reg);
                rcn_next = 16'd1;
            end
            DP_WALK_MARK:
            begin
                cur_next = fx;
                end_next = walk_end;
                rst_next = ST_OK;
                rfr_next = '0;
                rcn_next = '0;
            end
            DP_WALK_LOAD:
            begin
                word_next = used_q;
            end
            DP_WALK_BIT:
            begin
                word_next = word_upd;
                if (cur_bit && !nb)
                begin
                    ft_next = ft_reg + CW'(1);
                end
                else if (!cur_bit && nb)
                begin
                    ft_next = ft_reg - CW'(1);
                end
                cnt_we  = req_reg != REQ_MARK;
                used_we = stat.walk_last || stat.word_end;
                cur_next = cur_reg + XW'(1);
            end
            DP_FRAME_OP:
            begin
                cnt_waddr = FW'(frame_reg);
                rfr_next  = '0;
                rst_next  = ST_OK;
                rcn_next  = 16'(cnt_q);
                priority if (req_reg == REQ_READ)
                begin
                    rst_next = ST_OK;
                end
                else if (!fbit || ((req_reg == REQ_ADD_REF) && (cnt_q == '0)))
                begin
                    rst_next = ST_NOTALLOC;
                end
                else if (req_reg == REQ_ADD_REF)
                begin
                    if (cnt_q == CNT_MAX)
                    begin
                        rst_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_q + CNT_ONE;
                        rcn_next  = 16'(cnt_q + CNT_ONE);
                    end
                end
                else if (cnt_q > CNT_ONE)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_q - CNT_ONE;
                    rcn_next  = 16'(cnt_q - CNT_ONE);
                end
                else
                begin
                    // last reference gone: release the frame
                    cnt_we     = 1'b1;
                    cnt_wdata  = '0;
                    rcn_next   = '0;
                    used_we    = 1'b1;
                    used_waddr = AW'(frame_reg >> 6);
                    used_wdata = used_q & ~(64'd1 << frame_reg[5:0]);
                    ft_next    = ft_reg + CW'(1);
                end
            end
            DP_OUT_LOAD:
            begin
                ov_next = 1'b1;
                od_next = {13'(ft_reg), rcn_reg, rfr_reg, rst_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flim_reg <= FRAME_LIMIT_RST;
            ft_reg   <= '0;
            clr_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            flim_reg <= flim_next;
            ft_reg   <= ft_next;
            clr_reg  <= clr_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg   <= lim_next;
        len_reg   <= len_next;
        cur_reg   <= cur_next;
        end_reg   <= end_next;
        run_reg   <= run_next;
        start_reg <= start_next;
        req_reg   <= req_next;
        frame_reg <= frame_next;
        mu_reg    <= mu_next;
        word_reg  <= word_next;
        rst_reg   <= rst_next;
        rfr_reg   <= rfr_next;
        rcn_reg   <= rcn_next;
        od_reg    <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

>>> rtl/core/fralloc_ctrl.sv
// ---------------------------------------------------------------------------
// fralloc_ctrl
// Sequencer: clearing pass, decode, scan, walk, frame update and response.
// ---------------------------------------------------------------------------
module fralloc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fralloc_pkg::dp_stat_t stat,
    output fralloc_pkg::dp_cmd_t  cmd
);
    import fralloc_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DECODE   = 13'b0000000000100,
        S_SCAN_RD  = 13'b0000000001000,
        S_SCAN_EV  = 13'b0000000010000,
        S_SCAN_BIT = 13'b0000000100000,
        S_WALK_INI = 13'b0000001000000,
        S_WALK_RD  = 13'b0000010000000,
        S_WALK_LD  = 13'b0000100000000,
        S_WALK_BIT = 13'b0001000000000,
        S_FRAME_RD = 13'b0010000000000,
        S_FRAME_OP = 13'b0100000000000,
        S_RESP     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        cmd.code   = ST_OK;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.dec_alloc)
                begin
                    if (stat.len_bad || stat.len_oom)
                    begin
                        cmd.op     = DP_RESULT;
                        cmd.code   = stat.len_bad ? ST_INVALID : ST_OOM;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.op     = DP_SCAN_INIT;
                        state_next = S_SCAN_RD;
                    end
                end
                else if (stat.dec_frame)
                begin
                    if (stat.frame_bad)
                    begin
                        cmd.op     = DP_RESULT;
                        cmd.code   = ST_INVALID;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_FRAME_RD;
                    end
                end
                else if (stat.dec_mark)
                begin
                    if (stat.mark_nop)
                    begin
                        cmd.op     = DP_RESULT;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.op     = DP_WALK_MARK;
                        state_next = S_WALK_RD;
                    end
                end
                else
                begin
                    cmd.op     = DP_RESULT;
                    cmd.code   = ST_INVALID;
                    state_next = S_RESP;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.past_lim)
                begin
                    cmd.op     = DP_RESULT;
                    cmd.code   = ST_OOM;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                cmd.op = DP_SCAN_WORD;
                priority if (stat.word_found)
                begin
                    state_next = S_WALK_INI;
                end
                else if (stat.word_skip)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_SCAN_BIT;
                end
            end
            S_SCAN_BIT:
            begin
                priority if (stat.past_lim)
                begin
                    cmd.op     = DP_RESULT;
                    cmd.code   = ST_OOM;
                    state_next = S_RESP;
                end
                else if (stat.bit_found)
                begin
                    cmd.op     = DP_SCAN_BIT;
                    state_next = S_WALK_INI;
                end
                else
                begin
                    cmd.op = DP_SCAN_BIT;
                    if (stat.word_end)
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_WALK_INI:
            begin
                cmd.op     = DP_WALK_ALLOC;
                state_next = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_LD;
            end
            S_WALK_LD:
            begin
                cmd.op     = DP_WALK_LOAD;
                state_next = S_WALK_BIT;
            end
            S_WALK_BIT:
            begin
                cmd.op = DP_WALK_BIT;
                priority if (stat.walk_last)
                begin
                    state_next = S_RESP;
                end
                else if (stat.word_end)
                begin
                    state_next = S_WALK_RD;
                end
                else
                begin
                    state_next = S_WALK_BIT;
                end
            end
            S_FRAME_RD:
            begin
                cmd.op     = DP_FRAME_RD;
                state_next = S_FRAME_OP;
            end
            S_FRAME_OP:
            begin
                cmd.op     = DP_FRAME_OP;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
